// ===== design/primitive_assembler_defines.svh =====
// Assertion macros shared by the primitive assembler modules.
// Needs signals clk and rst_n in the module that uses them.
`ifndef PRIMITIVE_ASSEMBLER_DEFINES_SVH
`define PRIMITIVE_ASSEMBLER_DEFINES_SVH

// Checked on every rising edge outside reset.
`define PA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/pa_pkg.sv =====
// Package for the primitive assembler: widths, mode codes, face sizes and the
// control record that travels through the face queue. No dependencies.
`timescale 1ns / 1ps

package pa_pkg;

  localparam int INDEX_BITS_DEF  = 32;  // default stored index width
  localparam int VTX_W           = 32;  // index width on the ports
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef logic [2:0] mode_t;

  localparam mode_t MODE_POINTS    = 3'd0;
  localparam mode_t MODE_LINES     = 3'd1;
  localparam mode_t MODE_LINE_LOOP = 3'd2;
  localparam mode_t MODE_LINE_STRIP = 3'd3;
  localparam mode_t MODE_TRIS      = 3'd4;
  localparam mode_t MODE_TRI_STRIP = 3'd5;
  localparam mode_t MODE_TRI_FAN   = 3'd6;
  localparam mode_t MODE_RESET     = MODE_TRIS;

  typedef logic [1:0] fsize_t;

  localparam fsize_t SIZE_POINT = 2'd1;
  localparam fsize_t SIZE_LINE  = 2'd2;
  localparam fsize_t SIZE_TRI   = 2'd3;

  // One queue entry: a face, or a line loop's final segment plus its closing one.
  typedef struct packed {
    fsize_t size;
    logic   dual;       // two beats: (a,b) then (b,c)
    logic   last_prim;  // the item carried is_last
  } pa_ctl_t;

endpackage

// ===== design/pa_ifs.sv =====
// Channel interfaces of the primitive assembler: index input, face output and
// mode register write. Depends on pa_pkg.
`timescale 1ns / 1ps

interface pa_vtx_if;
  logic                     valid;
  logic                     ready;
  logic [pa_pkg::VTX_W-1:0] vertex_index;
  logic                     is_last;

  modport source (output valid, output vertex_index, output is_last, input ready);
  modport sink   (input valid, input vertex_index, input is_last, output ready);
endinterface

interface pa_face_if;
  logic                     valid;
  logic                     ready;
  pa_pkg::fsize_t           face_size;
  logic [pa_pkg::VTX_W-1:0] vert_a;
  logic [pa_pkg::VTX_W-1:0] vert_b;
  logic [pa_pkg::VTX_W-1:0] vert_c;
  logic                     last_of_item;
  logic                     last_of_primitive;

  modport source (output valid, output face_size, output vert_a, output vert_b,
                  output vert_c, output last_of_item, output last_of_primitive,
                  input ready);
  modport sink   (input valid, input face_size, input vert_a, input vert_b,
                  input vert_c, input last_of_item, input last_of_primitive,
                  output ready);
endinterface

interface pa_cfg_if;
  logic          valid;
  logic          ready;
  pa_pkg::mode_t prim_mode;

  modport source (output valid, output prim_mode, input ready);
  modport sink   (input valid, input prim_mode, output ready);
endinterface

// ===== design/pa_front.sv =====
// Front end of the primitive assembler: holds the mode register and assembly
// state, and turns each accepted index into at most one queue entry. Uses pa_pkg.
`timescale 1ns / 1ps
`include "primitive_assembler_defines.svh"

module pa_front #(
  parameter int IDX_W = pa_pkg::INDEX_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [pa_pkg::VTX_W-1:0] in_index,
  input  logic                     in_last,
  input  logic                     cfg_valid,
  input  pa_pkg::mode_t            cfg_mode,
  input  logic                     q_full,
  output logic                     q_push,
  output pa_pkg::pa_ctl_t          q_ctl,
  output logic [IDX_W-1:0]         q_a,
  output logic [IDX_W-1:0]         q_b,
  output logic [IDX_W-1:0]         q_c
);
  import pa_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic [IDX_W-1:0] first_r, first_nxt;
  logic [IDX_W-1:0] prev_r, prev_nxt;
  logic [IDX_W-1:0] pprev_r, pprev_nxt;
  logic [1:0]       seen_r, seen_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             odd_r, odd_nxt;
  logic             acc;
  logic [IDX_W-1:0] v;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign v        = in_index[IDX_W-1:0];

  always_comb begin
    mode_nxt  = mode_r;
    first_nxt = first_r;
    prev_nxt  = prev_r;
    pprev_nxt = pprev_r;
    seen_nxt  = seen_r;
    phase_nxt = phase_r;
    odd_nxt   = odd_r;
    q_push    = 1'b0;
    q_ctl     = '0;
    q_a       = '0;
    q_b       = '0;
    q_c       = '0;
    q_ctl.last_prim = in_last;

    if (acc) begin
      case (mode_r)
        MODE_POINTS: begin
          q_push     = 1'b1;
          q_ctl.size = SIZE_POINT;
          q_a        = v;
        end
        MODE_LINES: begin
          if (phase_r == 2'd0) begin
            prev_nxt  = v;
            phase_nxt = 2'd1;
          end else begin
            q_push     = 1'b1;
            q_ctl.size = SIZE_LINE;
            q_a        = prev_r;
            q_b        = v;
            phase_nxt  = 2'd0;
          end
        end
        MODE_LINE_LOOP, MODE_LINE_STRIP: begin
          if (seen_r == 2'd0) begin
            first_nxt = v;
          end else begin
            q_push     = 1'b1;
            q_ctl.size = SIZE_LINE;
            q_a        = prev_r;
            q_b        = v;
            // loop close travels in c and goes out as a second beat
            if (mode_r == MODE_LINE_LOOP && in_last) begin
              q_ctl.dual = 1'b1;
              q_c        = first_r;
            end
          end
          prev_nxt = v;
        end
        MODE_TRIS: begin
          if (phase_r == 2'd0) begin
            pprev_nxt = v;
            phase_nxt = 2'd1;
          end else if (phase_r == 2'd1) begin
            prev_nxt  = v;
            phase_nxt = 2'd2;
          end else begin
            q_push     = 1'b1;
            q_ctl.size = SIZE_TRI;
            q_a        = pprev_r;
            q_b        = prev_r;
            q_c        = v;
            phase_nxt  = 2'd0;
          end
        end
        MODE_TRI_STRIP: begin
          if (seen_r >= 2'd2) begin
            q_push     = 1'b1;
            q_ctl.size = SIZE_TRI;
            q_a        = odd_r ? prev_r : pprev_r;
            q_b        = odd_r ? pprev_r : prev_r;
            q_c        = v;
            odd_nxt    = !odd_r;
          end
          pprev_nxt = prev_r;
          prev_nxt  = v;
        end
        MODE_TRI_FAN: begin
          if (seen_r == 2'd0) begin
            first_nxt = v;
          end else if (seen_r >= 2'd2) begin
            q_push     = 1'b1;
            q_ctl.size = SIZE_TRI;
            q_a        = first_r;
            q_b        = prev_r;
            q_c        = v;
          end
          prev_nxt = v;
        end
        default: begin
        end
      endcase

      if (seen_r != 2'd3) seen_nxt = seen_r + 2'd1;
      if (in_last) begin
        first_nxt = '0;
        prev_nxt  = '0;
        pprev_nxt = '0;
        seen_nxt  = '0;
        phase_nxt = '0;
        odd_nxt   = 1'b0;
      end
    end

    if (cfg_valid) begin
      mode_nxt  = cfg_mode;
      first_nxt = '0;
      prev_nxt  = '0;
      pprev_nxt = '0;
      seen_nxt  = '0;
      phase_nxt = '0;
      odd_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RESET;
      first_r <= '0;
      prev_r  <= '0;
      pprev_r <= '0;
      seen_r  <= '0;
      phase_r <= '0;
      odd_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      first_r <= first_nxt;
      prev_r  <= prev_nxt;
      pprev_r <= pprev_nxt;
      seen_r  <= seen_nxt;
      phase_r <= phase_nxt;
      odd_r   <= odd_nxt;
    end
  end

  `PA_ASSERT(a_clear_after_last, (acc && in_last) |=> (seen_r == 2'd0 && phase_r == 2'd0), "assembly state not cleared after last index")
  `PA_ASSERT(a_dual_loop_only, (q_push && q_ctl.dual) |-> (mode_r == MODE_LINE_LOOP && in_last), "closing segment outside a line loop end")

endmodule

// ===== design/pa_queue.sv =====
// Short face queue between the front and back ends of the primitive
// assembler. Register file with one write and one read pointer. Uses pa_pkg.
`timescale 1ns / 1ps
`include "primitive_assembler_defines.svh"

module pa_queue #(
  parameter int IDX_W = pa_pkg::INDEX_BITS_DEF,
  parameter int DEPTH = pa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pa_pkg::pa_ctl_t  push_ctl,
  input  logic [IDX_W-1:0] push_a,
  input  logic [IDX_W-1:0] push_b,
  input  logic [IDX_W-1:0] push_c,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output pa_pkg::pa_ctl_t  head_ctl,
  output logic [IDX_W-1:0] head_a,
  output logic [IDX_W-1:0] head_b,
  output logic [IDX_W-1:0] head_c
);
  import pa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pa_ctl_t          ctl_mem [DEPTH];
  logic [IDX_W-1:0] a_mem   [DEPTH];
  logic [IDX_W-1:0] b_mem   [DEPTH];
  logic [IDX_W-1:0] c_mem   [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_ctl   = ctl_mem[rd_ptr_r];
  assign head_a     = a_mem[rd_ptr_r];
  assign head_b     = b_mem[rd_ptr_r];
  assign head_c     = c_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    if (push && !pop)      count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[wr_ptr_r] <= push_ctl;
      a_mem[wr_ptr_r]   <= push_a;
      b_mem[wr_ptr_r]   <= push_b;
      c_mem[wr_ptr_r]   <= push_c;
    end
  end

  `PA_ASSERT(a_no_overflow, !(push && full), "push into a full face queue")
  `PA_ASSERT(a_no_underflow, pop |-> head_valid, "pop from an empty face queue")

endmodule

// ===== design/pa_back.sv =====
// Back end of the primitive assembler: drains the face queue into a registered
// output stage, splitting a line loop's closing entry into two beats. Uses pa_pkg.
`timescale 1ns / 1ps
`include "primitive_assembler_defines.svh"

module pa_back #(
  parameter int IDX_W = pa_pkg::INDEX_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     head_valid,
  input  pa_pkg::pa_ctl_t          head_ctl,
  input  logic [IDX_W-1:0]         head_a,
  input  logic [IDX_W-1:0]         head_b,
  input  logic [IDX_W-1:0]         head_c,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output pa_pkg::fsize_t           out_size,
  output logic [pa_pkg::VTX_W-1:0] out_a,
  output logic [pa_pkg::VTX_W-1:0] out_b,
  output logic [pa_pkg::VTX_W-1:0] out_c,
  output logic                     out_last_item,
  output logic                     out_last_prim
);
  import pa_pkg::*;

  logic             valid_r, valid_nxt;
  logic             phase_r, phase_nxt;  // first beat of a dual entry has gone
  fsize_t           size_r, size_nxt;
  logic [IDX_W-1:0] a_r, a_nxt;
  logic [IDX_W-1:0] b_r, b_nxt;
  logic [IDX_W-1:0] c_r, c_nxt;
  logic             lit_r, lit_nxt;
  logic             lprim_r, lprim_nxt;
  logic             load;

  assign load = head_valid && (!valid_r || out_ready);
  assign pop  = load && (!head_ctl.dual || phase_r);

  always_comb begin
    valid_nxt = valid_r && !out_ready;
    phase_nxt = phase_r;
    size_nxt  = size_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    lit_nxt   = lit_r;
    lprim_nxt = lprim_r;
    if (load) begin
      valid_nxt = 1'b1;
      if (head_ctl.dual && !phase_r) begin
        phase_nxt = 1'b1;
        size_nxt  = SIZE_LINE;
        a_nxt     = head_a;
        b_nxt     = head_b;
        c_nxt     = '0;
        lit_nxt   = 1'b0;
        lprim_nxt = 1'b0;
      end else if (head_ctl.dual) begin
        phase_nxt = 1'b0;
        size_nxt  = SIZE_LINE;
        a_nxt     = head_b;
        b_nxt     = head_c;
        c_nxt     = '0;
        lit_nxt   = 1'b1;
        lprim_nxt = head_ctl.last_prim;
      end else begin
        phase_nxt = 1'b0;
        size_nxt  = head_ctl.size;
        a_nxt     = head_a;
        b_nxt     = head_b;
        c_nxt     = head_c;
        lit_nxt   = 1'b1;
        lprim_nxt = head_ctl.last_prim;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r  <= size_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    c_r     <= c_nxt;
    lit_r   <= lit_nxt;
    lprim_r <= lprim_nxt;
  end

  assign out_valid     = valid_r;
  assign out_size      = size_r;
  assign out_a         = VTX_W'(a_r);
  assign out_b         = VTX_W'(b_r);
  assign out_c         = VTX_W'(c_r);
  assign out_last_item = lit_r;
  assign out_last_prim = lprim_r;

  `PA_ASSERT(a_phase_on_dual, phase_r |-> (head_valid && head_ctl.dual), "second beat pending without a dual entry at the head")

endmodule

// ===== design/primitive_assembler.sv =====
// Primitive assembler top level: index channel in, face channel out, mode
// register write channel. Instantiates pa_front, pa_queue and pa_back; uses pa_pkg.
//
// Usage:
//   in_vtx   : one vertex index per beat, is_last on the primitive's final index.
//   out_face : one face per beat (point, line or triangle); last_of_item marks
//              the final face of an input beat, last_of_primitive that of a
//              beat that carried is_last.
//   cfg_wr   : writes prim_mode; always ready. Write only while the block is
//              idle; a write drops any primitive in progress.
// Throughput: one index per cycle while the queue has room. A face passes
//   through the queue register file and then the output register. A line loop's
//   last index gives two faces, which leave one after the other from the same
//   queue entry; the queue absorbs that extra beat.
// Reset: synchronous, active low; mode returns to triangles, state cleared,
//   queue and output emptied.
// Stalls: while out_face.ready is low the output register holds and the queue
//   (four entries by default) fills; in_vtx.ready drops only when it is full.
`timescale 1ns / 1ps

module primitive_assembler #(
  parameter int INDEX_BITS  = pa_pkg::INDEX_BITS_DEF,
  parameter int QUEUE_DEPTH = pa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pa_vtx_if.sink      in_vtx,
  pa_face_if.source   out_face,
  pa_cfg_if.sink      cfg_wr
);
  import pa_pkg::*;

  logic                  q_push;
  pa_ctl_t               q_push_ctl;
  logic [INDEX_BITS-1:0] q_push_a, q_push_b, q_push_c;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_head_valid;
  pa_ctl_t               q_head_ctl;
  logic [INDEX_BITS-1:0] q_head_a, q_head_b, q_head_c;

  assign cfg_wr.ready = 1'b1;

  pa_front #(.IDX_W(INDEX_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_vtx.valid),
    .in_ready  (in_vtx.ready),
    .in_index  (in_vtx.vertex_index),
    .in_last   (in_vtx.is_last),
    .cfg_valid (cfg_wr.valid),
    .cfg_mode  (cfg_wr.prim_mode),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ctl     (q_push_ctl),
    .q_a       (q_push_a),
    .q_b       (q_push_b),
    .q_c       (q_push_c)
  );

  pa_queue #(.IDX_W(INDEX_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ctl   (q_push_ctl),
    .push_a     (q_push_a),
    .push_b     (q_push_b),
    .push_c     (q_push_c),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_ctl   (q_head_ctl),
    .head_a     (q_head_a),
    .head_b     (q_head_b),
    .head_c     (q_head_c)
  );

  pa_back #(.IDX_W(INDEX_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (q_head_valid),
    .head_ctl      (q_head_ctl),
    .head_a        (q_head_a),
    .head_b        (q_head_b),
    .head_c        (q_head_c),
    .pop           (q_pop),
    .out_valid     (out_face.valid),
    .out_ready     (out_face.ready),
    .out_size      (out_face.face_size),
    .out_a         (out_face.vert_a),
    .out_b         (out_face.vert_b),
    .out_c         (out_face.vert_c),
    .out_last_item (out_face.last_of_item),
    .out_last_prim (out_face.last_of_primitive)
  );

endmodule

// ===== test/tb_primitive_assembler.sv =====
// Testbench for primitive_assembler: drives index beats and mode writes, predicts
// the faces each mode assembles and checks them in order on the face channel.
// Depends on pa_pkg and the channel interfaces in pa_ifs.sv.
`timescale 1ns / 1ps

module tb_primitive_assembler;
  import pa_pkg::*;

  localparam mode_t MODE_UNUSED    = 3'd7;
  localparam int    PREDICTED      = -1;   // row expectation comes from the predictor
  localparam int    SETTLE_CYCLES  = 4;
  localparam int    HOLD_CYCLES    = 80;
  localparam int    WATCHDOG_LIMIT = 2000;
  localparam int    PHASE_BEATS    = 470;

  typedef struct packed {
    fsize_t      face_size;
    logic [31:0] vert_a;
    logic [31:0] vert_b;
    logic [31:0] vert_c;
    logic        last_of_item;
    logic        last_of_primitive;
  } face_rec_t;

  typedef enum logic {ROW_MODE, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    mode_t       mode;
    logic [31:0] idx;
    logic        last;
    int          n_typed;
    face_rec_t   typed0;
    face_rec_t   typed1;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  pa_vtx_if  vtx_bus ();
  pa_face_if face_bus ();
  pa_cfg_if  cfg_bus ();

  primitive_assembler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vtx   (vtx_bus),
    .out_face (face_bus),
    .cfg_wr   (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Assembly state as the block should hold it
  mode_t       cur_mode;
  logic [31:0] first_v, prev_v, pprev_v;
  logic [1:0]  seen, phase;
  logic        strip_odd;

  face_rec_t pending_faces [$];
  dir_row_t  dir_rows [$];

  int errors = 0;
  int faces_checked = 0;
  int beats_sent = 0;
  int active_beats = 0;
  int mode_writes = 0;
  logic [7:0] modes_seen = '0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;

  function automatic face_rec_t mk_face(input fsize_t sz, input logic [31:0] a,
                                        input logic [31:0] b, input logic [31:0] c,
                                        input logic li, input logic lp);
    face_rec_t f;
    f.face_size = sz;
    f.vert_a = a;
    f.vert_b = b;
    f.vert_c = c;
    f.last_of_item = li;
    f.last_of_primitive = lp;
    return f;
  endfunction

  function automatic void expect_face(input face_rec_t f);
    pending_faces.insert(pending_faces.size(), f);
  endfunction

  function automatic void add_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void clear_assembly();
    first_v = '0;
    prev_v = '0;
    pprev_v = '0;
    seen = '0;
    phase = '0;
    strip_odd = 1'b0;
  endfunction

  function automatic void set_mode(input mode_t m);
    cur_mode = m;
    clear_assembly();
    modes_seen[m] = 1'b1;
    mode_writes++;
  endfunction

  // Faces caused by one accepted index; queued only when keep is set
  task automatic assemble(input logic [31:0] idx, input logic last, input bit keep);
    face_rec_t made [0:1];
    int n;
    n = 0;
    case (cur_mode)
      MODE_POINTS: begin
        made[n] = mk_face(SIZE_POINT, idx, '0, '0, 1'b0, 1'b0);
        n++;
      end
      MODE_LINES: begin
        if (phase == 2'd0) begin
          prev_v = idx;
          phase = 2'd1;
        end else begin
          made[n] = mk_face(SIZE_LINE, prev_v, idx, '0, 1'b0, 1'b0);
          n++;
          phase = 2'd0;
        end
      end
      MODE_LINE_LOOP, MODE_LINE_STRIP: begin
        if (seen == 2'd0) begin
          first_v = idx;
        end else begin
          made[n] = mk_face(SIZE_LINE, prev_v, idx, '0, 1'b0, 1'b0);
          n++;
          // loop closes back to its first index
          if (cur_mode == MODE_LINE_LOOP && last) begin
            made[n] = mk_face(SIZE_LINE, idx, first_v, '0, 1'b0, 1'b0);
            n++;
          end
        end
        prev_v = idx;
      end
      MODE_TRIS: begin
        if (phase == 2'd0) begin
          pprev_v = idx;
          phase = 2'd1;
        end else if (phase == 2'd1) begin
          prev_v = idx;
          phase = 2'd2;
        end else begin
          made[n] = mk_face(SIZE_TRI, pprev_v, prev_v, idx, 1'b0, 1'b0);
          n++;
          phase = 2'd0;
        end
      end
      MODE_TRI_STRIP: begin
        if (seen >= 2'd2) begin
          // odd triangles swap the first two to keep the winding
          if (strip_odd) made[n] = mk_face(SIZE_TRI, prev_v, pprev_v, idx, 1'b0, 1'b0);
          else made[n] = mk_face(SIZE_TRI, pprev_v, prev_v, idx, 1'b0, 1'b0);
          n++;
          strip_odd = ~strip_odd;
        end
        pprev_v = prev_v;
        prev_v = idx;
      end
      MODE_TRI_FAN: begin
        if (seen == 2'd0) begin
          first_v = idx;
        end else if (seen >= 2'd2) begin
          made[n] = mk_face(SIZE_TRI, first_v, prev_v, idx, 1'b0, 1'b0);
          n++;
        end
        prev_v = idx;
      end
      default: ;
    endcase
    if (n > 0) begin
      made[n-1].last_of_item = 1'b1;
      made[n-1].last_of_primitive = last;
    end
    if (keep)
      for (int k = 0; k < n; k++) expect_face(made[k]);
    if (seen != 2'd3) seen++;
    if (last) clear_assembly();
  endtask

  task automatic send_beat(input logic [31:0] idx, input logic last, input bit keep);
    while ($urandom_range(99) < send_idle) begin
      vtx_bus.valid <= 1'b0;
      @(negedge clk);
    end
    vtx_bus.valid <= 1'b1;
    vtx_bus.vertex_index <= idx;
    vtx_bus.is_last <= last;
    @(posedge clk);
    while (!vtx_bus.ready) @(posedge clk);
    if (cur_mode != MODE_UNUSED) active_beats++;
    assemble(idx, last, keep);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain_faces();
    vtx_bus.valid <= 1'b0;
    while (pending_faces.size() != 0) @(negedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    drain_faces();
    // beats that give no face may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.prim_mode <= m;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    set_mode(m);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic mode_t pick_mode();
    if ($urandom_range(19) == 0) return MODE_UNUSED;
    return mode_t'($urandom_range(6));
  endfunction

  function automatic logic [31:0] pick_index();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic dir_row_t beat_row(input logic [31:0] idx, input logic last);
    dir_row_t r;
    r.kind = ROW_BEAT;
    r.mode = MODE_RESET;
    r.idx = idx;
    r.last = last;
    r.n_typed = PREDICTED;
    r.typed0 = '0;
    r.typed1 = '0;
    return r;
  endfunction

  function automatic dir_row_t typed_row(input logic [31:0] idx, input logic last,
                                         input int n, input face_rec_t f0,
                                         input face_rec_t f1);
    dir_row_t r;
    r = beat_row(idx, last);
    r.n_typed = n;
    r.typed0 = f0;
    r.typed1 = f1;
    return r;
  endfunction

  function automatic dir_row_t mode_row(input mode_t m);
    dir_row_t r;
    r = beat_row('0, 1'b0);
    r.kind = ROW_MODE;
    r.mode = m;
    return r;
  endfunction

  task automatic build_directed();
    // triangles straight out of reset, extreme indices
    add_row(typed_row(32'h0, 1'b0, 0, '0, '0));
    add_row(typed_row(32'hFFFF_FFFF, 1'b0, 0, '0, '0));
    add_row(typed_row(32'd5, 1'b1, 1,
            mk_face(SIZE_TRI, 32'h0, 32'hFFFF_FFFF, 32'd5, 1'b1, 1'b1), '0));
    add_row(mode_row(MODE_POINTS));
    add_row(typed_row(32'hFFFF_FFFF, 1'b1, 1,
            mk_face(SIZE_POINT, 32'hFFFF_FFFF, '0, '0, 1'b1, 1'b1), '0));
    add_row(typed_row(32'h0, 1'b0, 1,
            mk_face(SIZE_POINT, 32'h0, '0, '0, 1'b1, 1'b0), '0));
    // lines with a dangling half pair
    add_row(mode_row(MODE_LINES));
    add_row(beat_row(32'd7, 1'b0));
    add_row(beat_row(32'd8, 1'b0));
    add_row(beat_row(32'd9, 1'b1));
    // two-index loop gives the segment and its reverse; lone index gives nothing
    add_row(mode_row(MODE_LINE_LOOP));
    add_row(typed_row(32'd10, 1'b0, 0, '0, '0));
    add_row(typed_row(32'd11, 1'b1, 2,
            mk_face(SIZE_LINE, 32'd10, 32'd11, '0, 1'b0, 1'b0),
            mk_face(SIZE_LINE, 32'd11, 32'd10, '0, 1'b1, 1'b1)));
    add_row(typed_row(32'd12, 1'b1, 0, '0, '0));
    add_row(mode_row(MODE_LINE_STRIP));
    add_row(beat_row(32'd20, 1'b0));
    add_row(beat_row(32'd21, 1'b0));
    add_row(beat_row(32'd22, 1'b1));
    add_row(mode_row(MODE_TRI_STRIP));
    for (int k = 30; k < 35; k++) add_row(beat_row(k, k == 34));
    add_row(beat_row(32'd40, 1'b1));
    add_row(mode_row(MODE_TRI_FAN));
    for (int k = 50; k < 53; k++) add_row(beat_row(k, k == 52));
    // a mode write drops the triangle in progress
    add_row(mode_row(MODE_TRIS));
    add_row(beat_row(32'd1, 1'b0));
    add_row(mode_row(MODE_TRIS));
    for (int k = 70; k < 73; k++) add_row(beat_row(k, k == 72));
    add_row(mode_row(MODE_UNUSED));
    add_row(typed_row(32'd60, 1'b1, 0, '0, '0));
  endtask

  task automatic run_phase(input int beats, input int s_idle, input int r_idle);
    int target;
    int len;
    bit abandon;
    logic last;
    target = active_beats + beats;
    send_idle = s_idle;
    recv_idle = r_idle;
    while (active_beats < target) begin
      if ($urandom_range(99) < 30) write_mode(pick_mode());
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 12) : $urandom_range(9, 1);
      abandon = ($urandom_range(19) == 0);
      for (int k = 0; k < len; k++) begin
        last = (k == len - 1) && !abandon;
        if ($urandom_range(24) == 0) last = 1'b1;
        send_beat(pick_index(), last, 1'b1);
      end
      if (abandon) write_mode(pick_mode());
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Receiver: random ready, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      face_bus.ready <= 1'b0;
    end else begin
      face_bus.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    face_rec_t got;
    face_rec_t want;
    if (rst_n && face_bus.valid && face_bus.ready) begin
      got = mk_face(face_bus.face_size, face_bus.vert_a, face_bus.vert_b,
                    face_bus.vert_c, face_bus.last_of_item, face_bus.last_of_primitive);
      if (pending_faces.size() == 0) begin
        errors++;
        $display("%0t: face beat with nothing expected, actual %p", $time, got);
      end else begin
        want = pending_faces.pop_front();
        faces_checked++;
        check_field("face_size", 32'(want.face_size), 32'(got.face_size));
        check_field("vert_a", want.vert_a, got.vert_a);
        check_field("vert_b", want.vert_b, got.vert_b);
        check_field("vert_c", want.vert_c, got.vert_c);
        check_field("last_of_item", 32'(want.last_of_item), 32'(got.last_of_item));
        check_field("last_of_primitive", 32'(want.last_of_primitive),
                    32'(got.last_of_primitive));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (vtx_bus.valid && vtx_bus.ready) || (face_bus.valid && face_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d faces outstanding", $time,
               stall_cycles, pending_faces.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    dir_row_t r;
    rst_n = 1'b0;
    vtx_bus.valid = 1'b0;
    vtx_bus.vertex_index = '0;
    vtx_bus.is_last = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.prim_mode = MODE_RESET;
    face_bus.ready = 1'b0;
    cur_mode = MODE_RESET;
    modes_seen[MODE_RESET] = 1'b1;
    clear_assembly();
    build_directed();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle = 12;
    recv_idle = 88;
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_MODE) begin
        write_mode(r.mode);
      end else if (r.n_typed == PREDICTED) begin
        send_beat(r.idx, r.last, 1'b1);
      end else begin
        // typed faces queued ahead of the beat; predictor only tracks state
        if (r.n_typed > 0) expect_face(r.typed0);
        if (r.n_typed > 1) expect_face(r.typed1);
        send_beat(r.idx, r.last, 1'b0);
      end
    end

    run_phase(PHASE_BEATS, 12, 88);
    run_phase(PHASE_BEATS, 88, 12);

    // back-pressure: closing loops fill the queue while the receiver holds off
    write_mode(MODE_LINE_LOOP);
    send_idle = 0;
    recv_idle = 0;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    for (int k = 0; k < 40; k++) send_beat($urandom, k % 2 == 1, 1'b1);
    drain_faces();

    run_phase(PHASE_BEATS, 0, 0);

    drain_faces();
    repeat (10) @(posedge clk);
    if (pending_faces.size() != 0) begin
      errors++;
      $display("%0t: %0d expected faces never arrived", $time, pending_faces.size());
    end
    $display("Run covered %0d index beats (%0d in assembling modes), %0d mode writes,",
             beats_sent, active_beats, mode_writes);
    $display("modes used %b, %0d faces compared, %0d mismatches.", modes_seen,
             faces_checked, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== primitive_assembler.f =====
+incdir+design
design/pa_pkg.sv
design/pa_ifs.sv
design/pa_front.sv
design/pa_queue.sv
design/pa_back.sv
design/primitive_assembler.sv
test/tb_primitive_assembler.sv
